// ===== hw/rtl/mlqs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mlqs_pkg: shared types and constants for the multilevel queue scheduler
// Sizes, request and level codes, controller states and the command and
// status words that join the controller to the datapath.
// ----------------------------------------------------------------------------
package mlqs_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int BURST_W   = 16;
  localparam int TIME_W    = 20;
  localparam int LEVEL_W   = 2;
  localparam int PROC_ID_W = 4;
  localparam int CFG_IDX_W = 2;

  // request codes
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_SLICE = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL2_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1_QUANTUM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL2_QUANTUM = 2'd3;

  // queue levels
  localparam logic [LEVEL_W-1:0] LEVEL_NONE = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_1    = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_2    = 2'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_3    = 2'd3;

  // register reset values
  localparam logic [BURST_W-1:0] LEVEL1_LIMIT_RST   = 16'd4;
  localparam logic [BURST_W-1:0] LEVEL2_LIMIT_RST   = 16'd8;
  localparam logic [BURST_W-1:0] LEVEL1_QUANTUM_RST = 16'd4;
  localparam logic [BURST_W-1:0] LEVEL2_QUANTUM_RST = 16'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RUN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                 load;
    logic                 clear;
    logic                 report_empty;
    logic                 scan_init;
    logic                 scan;
    logic                 run;
    logic                 emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic any_pending;
    logic hit;
  } dp_status_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [BURST_W-1:0] remaining;
  } entry_t;

  // advance a process index, wrapping at the table depth
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] r;
    if (idx == IDX_W'(MAX_PROCS - 1)) begin
      r = '0;
    end else begin
      r = idx + 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/multilevel_queue_scheduler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multilevel_queue_scheduler: three-level process scheduler
// Loads processes into three levels by burst time and hands out execution
// slices: levels 1 and 2 round robin with their own quantum, level 3 FCFS.
// ----------------------------------------------------------------------------
// Using the block: raise start with req_type and burst_time while busy is
// low. Loads, clears and unused codes are taken while the sequencer stays
// idle, so busy never rises. A slice request with work left raises busy and
// steps through scan, run and output; the scan reads the process table
// memory, which gives one entry per cycle, until it finds the next runnable
// entry of the serving level. A slice request with no work left returns the
// all_finished word in the next cycle. Every result word is shown for
// exactly one cycle with result_valid high; there is no way to hold it off,
// so sample it then. Configuration writes are taken whenever busy is low
// (cfg_ready mirrors that) and must not overlap pending work. Time runs on
// across levels and wraps at 2^20; a clear resets time and the process list
// but keeps the configuration.
// ----------------------------------------------------------------------------
module multilevel_queue_scheduler import mlqs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           req_type,
  input  wire logic [BURST_W-1:0]   burst_time,
  output logic                      result_valid,
  output logic [PROC_ID_W-1:0]      proc_id,
  output logic [TIME_W-1:0]         slice_start,
  output logic [TIME_W-1:0]         slice_end,
  output logic                      preempted,
  output logic [LEVEL_W-1:0]        level,
  output logic                      all_finished,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BURST_W-1:0]   cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       cfg_we;

  // take a config word only between requests
  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  mlqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .status   (status),
    .busy     (busy),
    .cmd      (cmd)
  );

  mlqs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .burst_time   (burst_time),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .proc_id      (proc_id),
    .slice_start  (slice_start),
    .slice_end    (slice_end),
    .preempted    (preempted),
    .level        (level),
    .all_finished (all_finished)
  );

  // a result word always lands after the sequencer has gone idle
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result word shown while busy");

  // the done word carries no slice
  a_done_word: assert property (@(posedge clk) disable iff (rst)
    (result_valid && all_finished) |->
      (proc_id == '0 && level == LEVEL_NONE && !preempted &&
       slice_start == '0 && slice_end == '0))
    else $error("done word carries slice fields");

  // a real slice names a level
  a_slice_level: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !all_finished) |->
      (level == LEVEL_1 || level == LEVEL_2 || level == LEVEL_3))
    else $error("slice without a level");

  // first come first served never leaves time behind
  a_fcfs_complete: assert property (@(posedge clk) disable iff (rst)
    (result_valid && level == LEVEL_3) |-> !preempted)
    else $error("level 3 slice preempted");

endmodule
`default_nettype wire

// ===== hw/rtl/mlqs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mlqs_ctrl: scheduler sequencer
// Decodes requests and steps a slice request through scan, run and output.
// ----------------------------------------------------------------------------
module mlqs_ctrl import mlqs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [1:0] req_type,
  input  wire dp_status_t status,
  output logic            busy,
  output ctrl_cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (req_type)
            REQ_LOAD:  cmd.load  = 1'b1;
            REQ_CLEAR: cmd.clear = 1'b1;
            REQ_SLICE: begin
              if (status.any_pending) begin
                cmd.scan_init = 1'b1;
                state_next    = ST_SCAN;
              end else begin
                cmd.report_empty = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.hit) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.run    = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mlqs_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mlqs_datapath: process table, level counters, timer and result registers
// Holds the configuration, the process memory and the slice arithmetic.
// ----------------------------------------------------------------------------
module mlqs_datapath import mlqs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ctrl_cmd_t            cmd,
  output dp_status_t                status,
  input  wire logic [BURST_W-1:0]   burst_time,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BURST_W-1:0]   cfg_data,
  output logic                      result_valid,
  output logic [PROC_ID_W-1:0]      proc_id,
  output logic [TIME_W-1:0]         slice_start,
  output logic [TIME_W-1:0]         slice_end,
  output logic                      preempted,
  output logic [LEVEL_W-1:0]        level,
  output logic                      all_finished
);

  logic [BURST_W-1:0] level1_limit;
  logic [BURST_W-1:0] level2_limit;
  logic [BURST_W-1:0] level1_quantum;
  logic [BURST_W-1:0] level2_quantum;

  entry_t mem [MAX_PROCS];

  logic [CNT_W-1:0]   proc_count;
  logic [CNT_W-1:0]   pend1;
  logic [CNT_W-1:0]   pend2;
  logic [CNT_W-1:0]   pend3;
  logic [LEVEL_W-1:0] serving_level;
  logic [IDX_W-1:0]   scan_index;
  logic [TIME_W-1:0]  clock_time;

  logic [IDX_W-1:0]   ptr;
  logic [IDX_W-1:0]   rd_addr;
  logic               rd_valid;
  entry_t             rd_data;
  logic [LEVEL_W-1:0] cur_level;
  logic [IDX_W-1:0]   hit_idx;
  logic [BURST_W-1:0] hit_rem;
  logic [BURST_W-1:0] run_len;
  logic               run_preempt;

  logic [LEVEL_W-1:0] sel_level;
  logic [LEVEL_W-1:0] load_level;
  logic               load_ok;
  logic               hit;
  logic [BURST_W-1:0] quantum;
  logic               finish;
  logic [BURST_W-1:0] run_amt;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;
  logic [TIME_W-1:0]  clock_sum;

  // lowest level with work left
  always_comb begin
    if (pend1 != '0) begin
      sel_level = LEVEL_1;
    end else if (pend2 != '0) begin
      sel_level = LEVEL_2;
    end else begin
      sel_level = LEVEL_3;
    end
  end

  always_comb begin
    if (burst_time <= level1_limit) begin
      load_level = LEVEL_1;
    end else if (burst_time <= level2_limit) begin
      load_level = LEVEL_2;
    end else begin
      load_level = LEVEL_3;
    end
  end

  assign load_ok = cmd.load && (proc_count < CNT_W'(MAX_PROCS));

  assign hit = rd_valid && (CNT_W'(rd_addr) < proc_count) &&
               (rd_data.level == cur_level) && (rd_data.remaining != '0);

  assign status.any_pending = (pend1 != '0) || (pend2 != '0) || (pend3 != '0);
  assign status.hit         = hit;

  // slice length: quantum of zero acts as one, level 3 runs to completion
  always_comb begin
    quantum = (cur_level == LEVEL_1) ? level1_quantum : level2_quantum;
    if (quantum == '0) begin
      quantum = BURST_W'(1);
    end
    finish  = (cur_level == LEVEL_3) || (hit_rem <= quantum);
    run_amt = finish ? hit_rem : quantum;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = hit_idx;
    mem_wdata = '{level: cur_level, remaining: hit_rem - run_amt};
    if (load_ok) begin
      mem_we    = 1'b1;
      mem_waddr = proc_count[IDX_W-1:0];
      mem_wdata = '{level: load_level, remaining: burst_time};
    end else if (cmd.run) begin
      mem_we = 1'b1;
    end
  end

  assign clock_sum = clock_time + TIME_W'(run_len);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[ptr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      level1_limit   <= LEVEL1_LIMIT_RST;
      level2_limit   <= LEVEL2_LIMIT_RST;
      level1_quantum <= LEVEL1_QUANTUM_RST;
      level2_quantum <= LEVEL2_QUANTUM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LEVEL1_LIMIT:   level1_limit   <= cfg_data;
        CFG_LEVEL2_LIMIT:   level2_limit   <= cfg_data;
        CFG_LEVEL1_QUANTUM: level1_quantum <= cfg_data;
        CFG_LEVEL2_QUANTUM: level2_quantum <= cfg_data;
        default: ;
      endcase
    end
  end

  // scheduler state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      proc_count    <= '0;
      pend1         <= '0;
      pend2         <= '0;
      pend3         <= '0;
      serving_level <= LEVEL_1;
      scan_index    <= '0;
      clock_time    <= '0;
    end else begin
      if (load_ok) begin
        proc_count <= proc_count + 1'b1;
        if (burst_time != '0) begin
          unique case (load_level)
            LEVEL_1: pend1 <= pend1 + 1'b1;
            LEVEL_2: pend2 <= pend2 + 1'b1;
            default: pend3 <= pend3 + 1'b1;
          endcase
        end
      end
      if (cmd.scan_init && (sel_level != serving_level)) begin
        serving_level <= sel_level;
        scan_index    <= '0;
      end
      if (cmd.run) begin
        scan_index <= next_idx(hit_idx);
        if (finish) begin
          unique case (cur_level)
            LEVEL_1: pend1 <= pend1 - 1'b1;
            LEVEL_2: pend2 <= pend2 - 1'b1;
            default: pend3 <= pend3 - 1'b1;
          endcase
        end
      end
      if (cmd.emit) begin
        clock_time <= clock_sum;
      end
    end
  end

  // scan pointer and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      rd_valid <= 1'b0;
    end else if (cmd.scan_init) begin
      ptr      <= (sel_level != serving_level) ? '0 : scan_index;
      rd_valid <= 1'b0;
    end else if (cmd.scan && !hit) begin
      ptr      <= next_idx(ptr);
      rd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      cur_level <= sel_level;
    end
    if (cmd.scan && !hit) begin
      rd_addr <= ptr;
    end
    if (cmd.scan && hit) begin
      hit_idx <= rd_addr;
      hit_rem <= rd_data.remaining;
    end
    if (cmd.run) begin
      run_len     <= run_amt;
      run_preempt <= !finish;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit || cmd.report_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      proc_id      <= PROC_ID_W'(hit_idx);
      slice_start  <= clock_time;
      slice_end    <= clock_sum;
      preempted    <= run_preempt;
      level        <= cur_level;
      all_finished <= 1'b0;
    end else if (cmd.report_empty) begin
      proc_id      <= '0;
      slice_start  <= '0;
      slice_end    <= '0;
      preempted    <= 1'b0;
      level        <= LEVEL_NONE;
      all_finished <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the multilevel queue scheduler
// Drives load, slice, clear and unused requests through the start/busy port,
// tracks the process table in a local scheduler model and checks every slice
// word the block emits against it. A short scripted part comes first, then
// randomized load-and-run sequences under several register settings and
// sender idle rates.
// ----------------------------------------------------------------------------
module tb_top import mlqs_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // code the package leaves unnamed: the block must ignore it
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int SCRIPT_ROWS = 25;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 140;
  localparam int SLICE_CAP   = 40;   // slices per sequence before giving up on it
  localparam int DRAIN_LIMIT = 200;  // cycles to wait for an outstanding word
  localparam int SETTLE      = 30;   // cycles to let a trailing request finish

  // one slice word as the block reports it
  typedef struct packed {
    logic [PROC_ID_W-1:0] pid;
    logic [TIME_W-1:0]    t_start;
    logic [TIME_W-1:0]    t_end;
    logic                 preempt;
    logic [LEVEL_W-1:0]   lvl;
    logic                 done;
  } slice_word_t;

  // one row of the scripted part; typed rows carry their word written out
  typedef struct packed {
    logic [1:0]         rq;
    logic [BURST_W-1:0] bt;
    logic [4:0]         reps;
    logic               typed;
    slice_word_t        want;
  } row_t;

  localparam slice_word_t NO_WORD   = '0;
  localparam slice_word_t DONE_WORD = '{pid: '0, t_start: '0, t_end: '0, preempt: 1'b0,
                                        lvl: LEVEL_NONE, done: 1'b1};

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [1:0]           req_type;
  logic [BURST_W-1:0]   burst_time;
  logic                 result_valid;
  logic [PROC_ID_W-1:0] proc_id;
  logic [TIME_W-1:0]    slice_start;
  logic [TIME_W-1:0]    slice_end;
  logic                 preempted;
  logic [LEVEL_W-1:0]   level;
  logic                 all_finished;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BURST_W-1:0]   cfg_data;

  multilevel_queue_scheduler dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .burst_time   (burst_time),
    .result_valid (result_valid),
    .proc_id      (proc_id),
    .slice_start  (slice_start),
    .slice_end    (slice_end),
    .preempted    (preempted),
    .level        (level),
    .all_finished (all_finished),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scheduler model: registers, process table and run state
  // --------------------------------------------------------------------------
  logic [BURST_W-1:0] lim1, lim2, qnt1, qnt2;
  logic [BURST_W-1:0] proc_left [MAX_PROCS];
  logic [LEVEL_W-1:0] proc_lvl  [MAX_PROCS];
  int                 n_procs;
  logic [LEVEL_W-1:0] serve_lvl;
  int                 scan_ptr;
  logic [TIME_W-1:0]  sched_time;

  slice_word_t slice_q [$];   // slice words still owed by the block
  slice_word_t last_word;     // word predicted for the latest slice request
  slice_word_t oldest;
  int          errors = 0;
  int          items  = 0;
  int          idle_pct = 0;

  // Hand out the next slice: lowest level with time left, round robin from the
  // scan pointer within it, level 3 running to completion.
  function automatic slice_word_t serve_slice();
    slice_word_t        w;
    logic [LEVEL_W-1:0] lv;
    logic [BURST_W-1:0] run, q;
    int                 idx, cand;
    bit                 found;
    w  = NO_WORD;
    lv = LEVEL_NONE;
    for (int i = 0; i < n_procs; i++)
      if (proc_left[i] != '0 && (lv == LEVEL_NONE || proc_lvl[i] < lv)) lv = proc_lvl[i];
    if (lv == LEVEL_NONE) return DONE_WORD;
    // switching levels restarts the round robin from the table head
    if (lv != serve_lvl) begin
      serve_lvl = lv;
      scan_ptr  = 0;
    end
    idx   = 0;
    found = 1'b0;
    for (int k = 0; k < MAX_PROCS; k++) begin
      cand = (scan_ptr + k) % MAX_PROCS;
      if (!found && cand < n_procs && proc_lvl[cand] == lv && proc_left[cand] != '0) begin
        idx   = cand;
        found = 1'b1;
      end
    end
    run = proc_left[idx];
    if (lv != LEVEL_3) begin
      q = (lv == LEVEL_1) ? qnt1 : qnt2;
      if (q == '0) q = 16'd1;   // a zero quantum still runs one tick
      if (run > q) run = q;
    end
    proc_left[idx] = proc_left[idx] - run;
    w.pid      = PROC_ID_W'(idx);
    w.t_start  = sched_time;
    sched_time = sched_time + TIME_W'(run);
    w.t_end    = sched_time;
    w.preempt  = (proc_left[idx] != '0);
    w.lvl      = lv;
    scan_ptr   = (idx + 1) % MAX_PROCS;
    return w;
  endfunction

  task automatic predict(input logic [1:0] rq, input logic [BURST_W-1:0] bt,
                         output bit has_word, output slice_word_t w);
    has_word = 1'b0;
    w        = NO_WORD;
    case (rq)
      REQ_LOAD: begin
        // a full table drops the load
        if (n_procs < MAX_PROCS) begin
          proc_left[n_procs] = bt;
          proc_lvl[n_procs]  = (bt <= lim1) ? LEVEL_1 : (bt <= lim2) ? LEVEL_2 : LEVEL_3;
          n_procs++;
        end
      end
      REQ_SLICE: begin
        w        = serve_slice();
        has_word = 1'b1;
      end
      REQ_CLEAR: begin
        n_procs    = 0;
        serve_lvl  = LEVEL_1;
        scan_ptr   = 0;
        sched_time = '0;
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Scripted part, run under the reset register values (limits 4/8, quanta 4/8)
  // --------------------------------------------------------------------------
  row_t script [SCRIPT_ROWS] = '{
    // nothing loaded yet: a slice request reports all finished
    '{REQ_SLICE,  16'd0,     5'd1,  1'b1, DONE_WORD},
    // a zero burst takes a table slot in level 1 but never runs
    '{REQ_LOAD,   16'd0,     5'd1,  1'b0, NO_WORD},
    '{REQ_SLICE,  16'd0,     5'd1,  1'b1, DONE_WORD},
    // largest burst goes to level 3, then one process for each lower level
    '{REQ_LOAD,   16'hFFFF,  5'd1,  1'b0, NO_WORD},
    '{REQ_LOAD,   16'd3,     5'd1,  1'b0, NO_WORD},
    '{REQ_LOAD,   16'd6,     5'd1,  1'b0, NO_WORD},
    // levels are served in strict order and time runs on across them
    '{REQ_SLICE,  16'hFFFF,  5'd1,  1'b1, '{4'd2, 20'd0, 20'd3, 1'b0, LEVEL_1, 1'b0}},
    '{REQ_SLICE,  16'd0,     5'd1,  1'b1, '{4'd3, 20'd3, 20'd9, 1'b0, LEVEL_2, 1'b0}},
    '{REQ_SLICE,  16'd0,     5'd1,  1'b1, '{4'd1, 20'd9, 20'd65544, 1'b0, LEVEL_3, 1'b0}},
    '{REQ_SLICE,  16'd0,     5'd1,  1'b1, DONE_WORD},
    // unused request code: no word, no state change
    '{REQ_UNUSED, 16'hFFFF,  5'd1,  1'b0, NO_WORD},
    '{REQ_CLEAR,  16'hFFFF,  5'd1,  1'b0, NO_WORD},
    '{REQ_SLICE,  16'd0,     5'd1,  1'b1, DONE_WORD},
    // a level 3 job first, then lower-level loads arriving late
    '{REQ_LOAD,   16'd9,     5'd1,  1'b0, NO_WORD},
    '{REQ_SLICE,  16'd0,     5'd1,  1'b0, NO_WORD},
    '{REQ_LOAD,   16'd4,     5'd1,  1'b0, NO_WORD},
    '{REQ_LOAD,   16'd5,     5'd1,  1'b0, NO_WORD},
    '{REQ_LOAD,   16'd8,     5'd1,  1'b0, NO_WORD},
    '{REQ_SLICE,  16'd0,     5'd1,  1'b0, NO_WORD},
    '{REQ_SLICE,  16'd0,     5'd1,  1'b0, NO_WORD},
    '{REQ_SLICE,  16'd0,     5'd1,  1'b0, NO_WORD},
    '{REQ_SLICE,  16'd0,     5'd1,  1'b0, NO_WORD},
    '{REQ_CLEAR,  16'd0,     5'd1,  1'b0, NO_WORD},
    // one load past capacity gets dropped, then run the full table dry
    '{REQ_LOAD,   16'd1,     5'd17, 1'b0, NO_WORD},
    '{REQ_SLICE,  16'd0,     5'd17, 1'b0, NO_WORD}
  };

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Hold start low until every owed word has shown up or DRAIN_LIMIT runs out.
  task automatic drain();
    int waited;
    waited = 0;
    start <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (slice_q.size() != 0 && waited < DRAIN_LIMIT);
    if (slice_q.size() != 0) begin
      $display("%0t: %0d slice words never arrived", $time, slice_q.size());
      errors++;
      slice_q.delete();
    end
  endtask

  // Present one request word and hold it until the block takes it. Busy is
  // read right at the edge, so it is the value the block saw at that edge.
  task automatic issue(input logic [1:0] rq, input logic [BURST_W-1:0] bt,
                       input bit typed, input slice_word_t want);
    slice_word_t w;
    bit          has_word;
    // now and then let everything drain before the next word
    if ($urandom_range(0, 59) == 0) drain();
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    start      <= 1'b1;
    req_type   <= rq;
    burst_time <= bt;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict(rq, bt, has_word, w);
    if (has_word) begin
      slice_q.push_back(typed ? want : w);
      last_word = w;
    end
    if (rq != REQ_UNUSED) items++;
  endtask

  // Write one register; cfg_valid stays up for a following write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BURST_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_LEVEL1_LIMIT:   lim1 = d;
      CFG_LEVEL2_LIMIT:   lim2 = d;
      CFG_LEVEL1_QUANTUM: qnt1 = d;
      default:            qnt2 = d;
    endcase
  endtask

  task automatic write_config(input logic [BURST_W-1:0] l1, l2, q1, q2);
    write_reg(CFG_LEVEL1_LIMIT, l1);
    write_reg(CFG_LEVEL2_LIMIT, l2);
    write_reg(CFG_LEVEL1_QUANTUM, q1);
    write_reg(CFG_LEVEL2_QUANTUM, q2);
    cfg_valid <= 1'b0;
  endtask

  // Bursts aimed at the level boundaries, short jobs and the top of the range.
  function automatic logic [BURST_W-1:0] pick_burst();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return lim1;
      2:       return lim1 + 16'd1;
      3:       return lim2;
      4:       return lim2 + 16'd1;
      5, 6:    return BURST_W'($urandom_range(1, 24));
      7:       return BURST_W'($urandom);
      8:       return 16'hFFFF - BURST_W'($urandom_range(0, 3));
      default: return BURST_W'($urandom_range(1, 300));
    endcase
  endfunction

  function automatic logic [BURST_W-1:0] pick_setting();
    return $urandom_range(0, 1) ? BURST_W'($urandom) : BURST_W'($urandom_range(0, 40));
  endfunction

  // Mostly whole runs: clear, load a batch, slice until all finished. Late
  // loads and unused codes get sprinkled in; some sequences skip the clear so
  // the table fills up, and a few are plain noise.
  task automatic run_phase(input int quota);
    int target, n, cnt, r;
    target = items + quota;
    while (items < target) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat (8) issue(2'($urandom_range(0, 3)), BURST_W'($urandom), 1'b0, NO_WORD);
      end else begin
        if (r >= 25) issue(REQ_CLEAR, BURST_W'($urandom), 1'b0, NO_WORD);
        n = $urandom_range(1, 18);
        repeat (n) begin
          if ($urandom_range(0, 19) == 0)
            issue(REQ_UNUSED, BURST_W'($urandom), 1'b0, NO_WORD);
          issue(REQ_LOAD, pick_burst(), 1'b0, NO_WORD);
        end
        cnt = 0;
        last_word = NO_WORD;
        while (!last_word.done && cnt < SLICE_CAP) begin
          if ($urandom_range(0, 9) == 0) issue(REQ_LOAD, pick_burst(), 1'b0, NO_WORD);
          issue(REQ_SLICE, BURST_W'($urandom), 1'b0, NO_WORD);
          cnt++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: a result word is up for exactly one cycle, so sample it in
  // the middle of that cycle and match it against the oldest owed word.
  // --------------------------------------------------------------------------
  function automatic void check_field(input string tag, input logic [TIME_W-1:0] want_v,
                                      input logic [TIME_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, tag, want_v, got_v);
      errors++;
    end
  endfunction

  always @(negedge clk) begin
    if (!rst && result_valid) begin
      if (slice_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, got pid %0d %0d..%0d lvl %0d fin %0d",
                 $time, proc_id, slice_start, slice_end, level, all_finished);
        errors++;
      end else begin
        oldest = slice_q.pop_front();
        check_field("proc_id", TIME_W'(oldest.pid), TIME_W'(proc_id));
        check_field("slice_start", oldest.t_start, slice_start);
        check_field("slice_end", oldest.t_end, slice_end);
        check_field("preempted", TIME_W'(oldest.preempt), TIME_W'(preempted));
        check_field("level", TIME_W'(oldest.lvl), TIME_W'(level));
        check_field("all_finished", TIME_W'(oldest.done), TIME_W'(all_finished));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    req_type   = REQ_LOAD;
    burst_time = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_LEVEL1_LIMIT;
    cfg_data   = '0;
    // model starts from the reset register values and an empty table
    lim1       = LEVEL1_LIMIT_RST;
    lim2       = LEVEL2_LIMIT_RST;
    qnt1       = LEVEL1_QUANTUM_RST;
    qnt2       = LEVEL2_QUANTUM_RST;
    n_procs    = 0;
    serve_lvl  = LEVEL_1;
    scan_ptr   = 0;
    sched_time = '0;
    last_word  = NO_WORD;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // walk the script, repeating rows that ask for it
    for (int r = 0; r < SCRIPT_ROWS; r++)
      repeat (script[r].reps) issue(script[r].rq, script[r].bt, script[r].typed, script[r].want);

    // random phases: first under reset values, then extremes, then fixed and random
    // settings; the sender idle rate cycles through none, 51%, none and 13%
    for (int p = 0; p < PHASES; p++) begin
      idle_pct = (p % 4 == 1) ? 51 : (p % 4 == 3) ? 13 : 0;
      if (p > 0) begin
        // registers only change with the block idle: drain, then let a
        // trailing load or clear finish
        drain();
        repeat (SETTLE) @(posedge clk);
        case (p)
          1:       write_config(16'd0, 16'd0, 16'd0, 16'd0);
          2:       write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          3:       write_config(16'd3, 16'd10, 16'd1, 16'd2);
          4:       write_config(16'd10, 16'd5, 16'd2, 16'hFFFF);
          default: write_config(pick_setting(), pick_setting(), pick_setting(), pick_setting());
        endcase
      end
      run_phase(PHASE_ITEMS);
    end

    drain();
    // watch a little longer for stray words
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mlqs_pkg.sv
hw/rtl/mlqs_ctrl.sv
hw/rtl/mlqs_datapath.sv
hw/rtl/multilevel_queue_scheduler.sv
tb/tb_top.sv
